@@ rtl/nsba_pkg.sv @@
// ----------------------------------------------------------------------------
// nsba_pkg
// Shared types and constants for the nearest-neighbor stretch blit address
// generator.
// ----------------------------------------------------------------------------
package nsba_pkg;

	localparam int POS_W   = 12;
	localparam int SPAN_W  = 13;
	localparam int STR_W   = 14;
	localparam int ADDR_W  = 32;
	localparam int PROD_W  = POS_W + SPAN_W;
	localparam int QUOT_W  = SPAN_W;
	localparam int CELLS   = QUOT_W;
	localparam int COORD_W = SPAN_W + 1;
	localparam int MUL_W   = COORD_W + STR_W;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_SRC_PITCH  = 3'd2,
		REG_SRC_BASE   = 3'd3,
		REG_DST_WIDTH  = 3'd4,
		REG_DST_HEIGHT = 3'd5,
		REG_DST_PITCH  = 3'd6,
		REG_DST_BASE   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]  src_left;
		logic [POS_W-1:0]  src_top;
		logic [SPAN_W-1:0] src_span_x;
		logic [SPAN_W-1:0] src_span_y;
		logic [POS_W-1:0]  dst_left;
		logic [POS_W-1:0]  dst_top;
		logic [SPAN_W-1:0] dst_span_x;
		logic [SPAN_W-1:0] dst_span_y;
		logic [POS_W-1:0]  out_col;
		logic [POS_W-1:0]  out_row;
	} req_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] src_address;
		logic [ADDR_W-1:0] dst_address;
		logic              bad_params;
	} rsp_t;

	typedef struct packed {
		logic [SPAN_W-1:0] src_width;
		logic [SPAN_W-1:0] src_height;
		logic [STR_W-1:0]  src_pitch;
		logic [ADDR_W-1:0] src_base;
		logic [SPAN_W-1:0] dst_width;
		logic [SPAN_W-1:0] dst_height;
		logic [STR_W-1:0]  dst_pitch;
		logic [ADDR_W-1:0] dst_base;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              bad;
		logic              in_range;
		logic [PROD_W-1:0] rem_y;
		logic [PROD_W-1:0] rem_x;
		logic [PROD_W-1:0] div_y;
		logic [PROD_W-1:0] div_x;
		logic [QUOT_W-1:0] quo_y;
		logic [QUOT_W-1:0] quo_x;
		logic [POS_W-1:0]  top;
		logic [POS_W-1:0]  left;
		logic [SPAN_W-1:0] dst_y;
		logic [SPAN_W-1:0] dst_x;
	} pkt_t;

endpackage

@@ rtl/nsba_cell.sv @@
// ----------------------------------------------------------------------------
// nsba_cell
// One restoring-division cell: settles one quotient bit for row and column.
// ----------------------------------------------------------------------------
module nsba_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  nsba_pkg::pkt_t pkt_in,
	output nsba_pkg::pkt_t pkt_out
);

	nsba_pkg::pkt_t nxt;
	nsba_pkg::pkt_t pkt_q;

	always_comb begin
		nxt = pkt_in;
		nxt.div_y = pkt_in.div_y >> 1;
		nxt.div_x = pkt_in.div_x >> 1;
		if (pkt_in.rem_y >= pkt_in.div_y) begin
			nxt.rem_y = pkt_in.rem_y - pkt_in.div_y;
			nxt.quo_y = {pkt_in.quo_y[nsba_pkg::QUOT_W-2:0], 1'b1};
		end else begin
			nxt.quo_y = {pkt_in.quo_y[nsba_pkg::QUOT_W-2:0], 1'b0};
		end
		if (pkt_in.rem_x >= pkt_in.div_x) begin
			nxt.rem_x = pkt_in.rem_x - pkt_in.div_x;
			nxt.quo_x = {pkt_in.quo_x[nsba_pkg::QUOT_W-2:0], 1'b1};
		end else begin
			nxt.quo_x = {pkt_in.quo_x[nsba_pkg::QUOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else if (adv) begin
			pkt_q <= nxt;
		end
	end

	assign pkt_out = pkt_q;

endmodule

@@ rtl/nsba_addr.sv @@
// ----------------------------------------------------------------------------
// nsba_addr
// Clip check, row-times-stride products and final byte address sums.
// ----------------------------------------------------------------------------
module nsba_addr (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  nsba_pkg::cfg_t cfg,
	input  nsba_pkg::pkt_t pkt_in,
	output logic           valid,
	output nsba_pkg::rsp_t rsp
);

	logic [nsba_pkg::COORD_W-1:0] sy, sx;
	logic                         ok;
	logic                         valid_s1, valid_s2;
	logic                         bad_s1, ok_s1;
	logic [nsba_pkg::MUL_W-1:0]   sprod_s1, dprod_s1;
	logic [nsba_pkg::COORD_W-1:0] sx_s1, dx_s1;
	logic [nsba_pkg::MUL_W-1:0]   ssum, dsum;
	nsba_pkg::rsp_t               rsp_s2;

	always_comb begin
		sy = nsba_pkg::COORD_W'(pkt_in.top) + nsba_pkg::COORD_W'(pkt_in.quo_y);
		sx = nsba_pkg::COORD_W'(pkt_in.left) + nsba_pkg::COORD_W'(pkt_in.quo_x);
		ok = !pkt_in.bad && pkt_in.in_range
			&& (sy < nsba_pkg::COORD_W'(cfg.src_height))
			&& (sx < nsba_pkg::COORD_W'(cfg.src_width));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pkt_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1   <= pkt_in.bad;
			ok_s1    <= ok;
			sprod_s1 <= nsba_pkg::MUL_W'(sy) * nsba_pkg::MUL_W'(cfg.src_pitch);
			dprod_s1 <= nsba_pkg::MUL_W'(pkt_in.dst_y) * nsba_pkg::MUL_W'(cfg.dst_pitch);
			sx_s1    <= sx;
			dx_s1    <= nsba_pkg::COORD_W'(pkt_in.dst_x);
		end
	end

	always_comb begin
		ssum = sprod_s1 + nsba_pkg::MUL_W'(sx_s1);
		dsum = dprod_s1 + nsba_pkg::MUL_W'(dx_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2.write_enable <= ok_s1;
			rsp_s2.bad_params   <= bad_s1;
			rsp_s2.src_address  <= ok_s1 ?
				cfg.src_base + nsba_pkg::ADDR_W'({ssum, 2'b00}) : '0;
			rsp_s2.dst_address  <= ok_s1 ?
				cfg.dst_base + nsba_pkg::ADDR_W'({dsum, 2'b00}) : '0;
		end
	end

	assign valid = valid_s2;
	assign rsp   = rsp_s2;

endmodule

@@ rtl/nearest_stretch_blit_address.sv @@
// ----------------------------------------------------------------------------
// nearest_stretch_blit_address
// Nearest-neighbor stretch blit source and destination address generator.
// ----------------------------------------------------------------------------
//  channel  signals                         direction
//  in       in_valid / in_ready / in_data   request in
//  out      out_valid / out_ready / out_data result out
//  cfg      cfg_we / cfg_index / cfg_data   register write
//
//  One request per cycle when not stalled; stages: input stage, 13 division cells
//  (one quotient bit each), stride multiply stage, address sum stage.
//  The whole pipeline advances together; it holds while out_valid is high
//  and out_ready is low. Reset clears registers and pipeline valid bits.
// ----------------------------------------------------------------------------
module nearest_stretch_blit_address (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  nsba_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output nsba_pkg::rsp_t  out_data,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data
);

	nsba_pkg::cfg_t cfg_q;
	logic           adv;
	nsba_pkg::pkt_t head;
	nsba_pkg::pkt_t head_s1;
	nsba_pkg::pkt_t chain [nsba_pkg::CELLS+1];
	logic [nsba_pkg::SPAN_W-1:0] dy, dx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (nsba_pkg::reg_idx_t'(cfg_index))
				nsba_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[nsba_pkg::SPAN_W-1:0];
				nsba_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[nsba_pkg::SPAN_W-1:0];
				nsba_pkg::REG_SRC_PITCH:  cfg_q.src_pitch  <= cfg_data[nsba_pkg::STR_W-1:0];
				nsba_pkg::REG_SRC_BASE:   cfg_q.src_base   <= cfg_data;
				nsba_pkg::REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data[nsba_pkg::SPAN_W-1:0];
				nsba_pkg::REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data[nsba_pkg::SPAN_W-1:0];
				nsba_pkg::REG_DST_PITCH:  cfg_q.dst_pitch  <= cfg_data[nsba_pkg::STR_W-1:0];
				nsba_pkg::REG_DST_BASE:   cfg_q.dst_base   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_comb begin
		dy = nsba_pkg::SPAN_W'(in_data.dst_top) + nsba_pkg::SPAN_W'(in_data.out_row);
		dx = nsba_pkg::SPAN_W'(in_data.dst_left) + nsba_pkg::SPAN_W'(in_data.out_col);
		head.valid    = in_valid;
		head.bad      = (in_data.src_span_x == '0) || (in_data.src_span_y == '0)
			|| (in_data.dst_span_x == '0) || (in_data.dst_span_y == '0)
			|| (cfg_q.src_base == '0) || (cfg_q.dst_base == '0);
		head.in_range = (nsba_pkg::SPAN_W'(in_data.out_col) < in_data.dst_span_x)
			&& (nsba_pkg::SPAN_W'(in_data.out_row) < in_data.dst_span_y)
			&& (dy < cfg_q.dst_height) && (dx < cfg_q.dst_width);
		head.rem_y    = nsba_pkg::PROD_W'(in_data.out_row) * nsba_pkg::PROD_W'(in_data.src_span_y);
		head.rem_x    = nsba_pkg::PROD_W'(in_data.out_col) * nsba_pkg::PROD_W'(in_data.src_span_x);
		head.div_y    = {in_data.dst_span_y, {(nsba_pkg::CELLS-1){1'b0}}};
		head.div_x    = {in_data.dst_span_x, {(nsba_pkg::CELLS-1){1'b0}}};
		head.quo_y    = '0;
		head.quo_x    = '0;
		head.top      = in_data.src_top;
		head.left     = in_data.src_left;
		head.dst_y    = dy;
		head.dst_x    = dx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s1 <= '0;
		end else if (adv) begin
			head_s1 <= head;
		end
	end

	assign chain[0] = head_s1;

	for (genvar i = 0; i < nsba_pkg::CELLS; i++) begin : g_cell
		nsba_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.pkt_in  (chain[i]),
			.pkt_out (chain[i+1])
		);
	end

	nsba_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.pkt_in (chain[nsba_pkg::CELLS]),
		.valid  (out_valid),
		.rsp    (out_data)
	);

`ifndef SYNTHESIS
	a_bad_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_params |-> !out_data.write_enable)
		else $error("bad_params with write_enable");
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_enable |->
		out_data.src_address == '0 && out_data.dst_address == '0)
		else $error("disabled pixel with nonzero address");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> head_s1.valid)
		else $error("accepted request lost at input stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(chain[nsba_pkg::CELLS].valid))
		else $error("pipeline moved during stall");
`endif

endmodule
